/* hdl/stm_pkg.sv */
// ----------------------------------------------------------------------------
// stm_pkg
// Shared types and constants for the stepper move-to-target block.
// ----------------------------------------------------------------------------
`default_nettype none

package stm_pkg;

  // Default values of the top-level parameters.
  localparam int TickNsDef      = 1000;
  localparam int UstepsPerRevDef = 6400;

  // Fixed arithmetic constants.
  localparam int          DivW          = 36;                 // bits of ns per minute
  localparam logic [35:0] NsPerMinute   = 36'd60000000000;
  localparam int          UstepsPerMm   = 6400;               // 100 hundredths x 64
  localparam int          DistLimit     = 100;
  localparam logic [9:0]  RpmMin        = 10'd50;
  localparam logic [9:0]  RpmMax        = 10'd800;
  localparam logic [9:0]  RpmReset      = 10'd100;
  localparam logic [17:0] IntervalMax   = 18'h3FFFF;
  localparam logic [19:0] ElapsedMax    = 20'hFFFFF;

  // Result status codes.
  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusRange    = 2'd1;
  localparam logic [1:0] StatusZero     = 2'd2;
  localparam logic [1:0] StatusBusy     = 2'd3;

  typedef struct packed {
    logic              func;
    logic signed [7:0] move_mm;
  } in_t;

  typedef struct packed {
    logic               step_pulse;
    logic               direction;
    logic signed [31:0] position;
    logic               moving;
    logic               done_res;
    logic [1:0]         status;
  } out_t;

  // Controller to datapath.
  typedef struct packed {
    logic load_in;
    logic exec;
    logic mul;
    logic div_start;
    logic fin;
    logic load_out;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_move;
    logic cmd_ok;
    logic div_done;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

/* hdl/stm_div.sv */
// ----------------------------------------------------------------------------
// stm_div
// Restoring divider of the nanoseconds in one minute by the step rate
// denominator, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module stm_div #(
  parameter int DEN_W = 27
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [DEN_W-1:0]          den_i,
  output logic [stm_pkg::DivW-1:0]       quo_o,
  output logic                           done_o
);

  localparam int CntW = $clog2(stm_pkg::DivW);
  localparam logic [CntW-1:0] CntLast = CntW'(stm_pkg::DivW - 1);

  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic [DEN_W-1:0]           rem_q, rem_d;
  logic [stm_pkg::DivW-1:0]   quo_q, quo_d;
  logic [DEN_W:0]             rem_shift;
  logic [DEN_W:0]             rem_diff;

  assign rem_shift = {rem_q, quo_q[stm_pkg::DivW-1]};
  assign rem_diff  = rem_shift - {1'b0, den_i};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = stm_pkg::NsPerMinute;
    end else if (busy_q) begin
      if (rem_shift >= {1'b0, den_i}) begin
        rem_d = rem_diff[DEN_W-1:0];
        quo_d = {quo_q[stm_pkg::DivW-2:0], 1'b1};
      end else begin
        rem_d = rem_shift[DEN_W-1:0];
        quo_d = {quo_q[stm_pkg::DivW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntLast) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign quo_o  = quo_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

/* hdl/stm_datapath.sv */
// ----------------------------------------------------------------------------
// stm_datapath
// Position, target and timing registers, command checks, the step update
// and the output register of the stepper move-to-target block.
// ----------------------------------------------------------------------------
`default_nettype none

module stm_datapath #(
  parameter int TICK_NS            = stm_pkg::TickNsDef,
  parameter int MICROSTEPS_PER_REV = stm_pkg::UstepsPerRevDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire stm_pkg::in_t    in_data_i,
  input  wire logic            cfg_we_i,
  input  wire logic [9:0]      cfg_data_i,
  input  wire stm_pkg::dp_cmd_t cmd_i,
  output stm_pkg::dp_sts_t     sts_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output stm_pkg::out_t        out_data_o
);

  localparam int DenW = 10 + $clog2(MICROSTEPS_PER_REV + 1);

  logic [9:0]         rpm_q;
  logic               func_q;
  logic signed [7:0]  dist_q;
  logic signed [31:0] pos_q;
  logic signed [31:0] target_q;
  logic [19:0]        elapsed_q;
  logic [17:0]        interval_q;
  logic               moving_q;
  logic               dir_q;
  logic               pulse_q;
  logic               done_q;
  logic [1:0]         status_q;
  logic [DenW-1:0]    den_q;
  logic               out_valid_q;
  stm_pkg::out_t      out_q;

  logic [9:0]                 rpm_clamp;
  logic [1:0]                 cmd_status;
  logic signed [20:0]         offset;
  logic signed [32:0]         target_sum;
  logic signed [31:0]         target_sat;
  logic [20:0]                elapsed_sum;
  logic [19:0]                elapsed_sat;
  logic                       step_due;
  logic                       fwd;
  logic signed [31:0]         pos_next;
  logic [stm_pkg::DivW-1:0]   quo;
  logic                       div_done;

  // Move command checks, in priority order.
  always_comb begin
    if (dist_q < -8'sd100 || dist_q > 8'sd100) begin
      cmd_status = stm_pkg::StatusRange;
    end else if (dist_q == 8'sd0) begin
      cmd_status = stm_pkg::StatusZero;
    end else if (moving_q) begin
      cmd_status = stm_pkg::StatusBusy;
    end else begin
      cmd_status = stm_pkg::StatusOk;
    end
  end

  assign offset     = 21'(dist_q) * 21'(stm_pkg::UstepsPerMm);
  assign target_sum = 33'(pos_q) + 33'(offset);
  // Overflow shows as a mismatch of the two top bits; the sign picks the rail.
  assign target_sat = (target_sum[32] != target_sum[31]) ?
                      (target_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) :
                      target_sum[31:0];

  assign elapsed_sum = 21'(elapsed_q) + 21'(TICK_NS);
  assign elapsed_sat = elapsed_sum[20] ? stm_pkg::ElapsedMax : elapsed_sum[19:0];
  assign step_due    = elapsed_sat >= {2'b00, interval_q};
  assign fwd         = target_q > pos_q;
  assign pos_next    = fwd ? pos_q + 32'sd1 : pos_q - 32'sd1;

  assign rpm_clamp = (rpm_q < stm_pkg::RpmMin) ? stm_pkg::RpmMin :
                     (rpm_q > stm_pkg::RpmMax) ? stm_pkg::RpmMax : rpm_q;

  stm_div #(
    .DEN_W (DenW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .den_i   (den_q),
    .quo_o   (quo),
    .done_o  (div_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rpm_q       <= stm_pkg::RpmReset;
      pos_q       <= '0;
      target_q    <= '0;
      elapsed_q   <= '0;
      interval_q  <= '0;
      moving_q    <= 1'b0;
      dir_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        rpm_q <= cfg_data_i;
      end
      if (cmd_i.exec) begin
        if (func_q) begin
          if (cmd_status == stm_pkg::StatusOk) begin
            target_q  <= target_sat;
            elapsed_q <= '0;
          end
        end else if (moving_q) begin
          if (step_due) begin
            dir_q     <= ~fwd;
            pos_q     <= pos_next;
            elapsed_q <= '0;
            if (pos_next == target_q) begin
              moving_q <= 1'b0;
            end
          end else begin
            elapsed_q <= elapsed_sat;
          end
        end
      end
      if (cmd_i.fin) begin
        interval_q <= (quo > stm_pkg::DivW'(stm_pkg::IntervalMax)) ?
                      stm_pkg::IntervalMax : quo[17:0];
        moving_q   <= target_q != pos_q;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      func_q <= in_data_i.func;
      dist_q <= in_data_i.move_mm;
    end
    if (cmd_i.exec) begin
      status_q <= func_q ? cmd_status : stm_pkg::StatusOk;
      pulse_q  <= !func_q && moving_q && step_due;
      done_q   <= !func_q && moving_q && step_due && (pos_next == target_q);
    end
    if (cmd_i.mul) begin
      den_q <= DenW'(rpm_clamp) * DenW'(MICROSTEPS_PER_REV);
    end
    if (cmd_i.load_out) begin
      out_q.step_pulse <= pulse_q;
      out_q.direction  <= dir_q;
      out_q.position   <= pos_q;
      out_q.moving     <= moving_q;
      out_q.done_res   <= done_q;
      out_q.status     <= status_q;
    end
  end

  assign sts_o.is_move  = func_q;
  assign sts_o.cmd_ok   = cmd_status == stm_pkg::StatusOk;
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

/* hdl/stm_ctrl.sv */
// ----------------------------------------------------------------------------
// stm_ctrl
// Sequencer of the stepper move-to-target block: takes an item, runs the
// tick update or the move command with its interval division, and hands
// the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module stm_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire stm_pkg::dp_sts_t sts_i,
  output stm_pkg::dp_cmd_t      cmd_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StExec  = 3'd1;
  localparam logic [2:0] StMul   = 3'd2;
  localparam logic [2:0] StStart = 3'd3;
  localparam logic [2:0] StDiv   = 3'd4;
  localparam logic [2:0] StFin   = 3'd5;
  localparam logic [2:0] StPush  = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = StExec;
        end
      end
      StExec: begin
        cmd_o.exec = 1'b1;
        state_d    = (sts_i.is_move && sts_i.cmd_ok) ? StMul : StPush;
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StStart;
      end
      StStart: begin
        cmd_o.div_start = 1'b1;
        state_d         = StDiv;
      end
      StDiv: begin
        if (sts_i.div_done) begin
          state_d = StFin;
        end
      end
      StFin: begin
        cmd_o.fin = 1'b1;
        state_d   = StPush;
      end
      StPush: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = state_q != StIdle;

endmodule

`default_nettype wire

/* hdl/stepper_move_to_target.sv */
// ----------------------------------------------------------------------------
// stepper_move_to_target
// Step and direction generator: move commands set a target and a step
// interval, time ticks advance the position one microstep at a time.
//
//   Channel   Dir  Handshake               Payload
//   in        in   in_valid_i/in_stall_o   in_data_i  (func, move_mm)
//   out       out  out_valid_o/out_stall_i out_data_o (step, dir, position, ...)
//   cfg       in   cfg_we_i                cfg_data_i (step_speed_rpm)
//
// A tick or a rejected command passes the execute and push states after the
// input transfer; the input opens again in the same cycle as the result shows.
// An accepted move command also passes the multiply, start, divide and finish
// states; the 36-step restoring divider computes the step interval.
// Reset clears position, target, timing state and the speed to 100 rpm.
// A stalled output holds the next result in the sequencer until it drains.
// ----------------------------------------------------------------------------
`default_nettype none

module stepper_move_to_target #(
  parameter int TICK_NS            = stm_pkg::TickNsDef,
  parameter int MICROSTEPS_PER_REV = stm_pkg::UstepsPerRevDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire stm_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output stm_pkg::out_t      out_data_o,
  input  wire logic          cfg_we_i,
  input  wire logic [9:0]    cfg_data_i
);

  stm_pkg::dp_cmd_t cmd;
  stm_pkg::dp_sts_t sts;

  stm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  stm_datapath #(
    .TICK_NS            (TICK_NS),
    .MICROSTEPS_PER_REV (MICROSTEPS_PER_REV)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // After a transfer in, the block works on that item before taking another.
  a_busy_after_in : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while an item is in progress");

  // Arrival always comes with the final step and ends the move.
  a_done_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.done_res |-> out_data_o.step_pulse && !out_data_o.moving)
    else $error("done without a final step");

  // A rejected command moves nothing.
  a_reject_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != stm_pkg::StatusOk
    |-> !out_data_o.step_pulse && !out_data_o.done_res)
    else $error("step issued on a rejected command");

endmodule

`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for stepper_move_to_target. A scoreboard class predicts
// one report per transfer on the input channel and compares every report
// field by field. Directed commands cover the range, zero and busy checks
// in their priority order, then a short reverse move is started and stepped
// under random traffic with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb;

  localparam int              ClkPeriod     = 10;
  localparam int              TickNs        = stm_pkg::TickNsDef;
  localparam int              UstepsPerRev  = stm_pkg::UstepsPerRevDef;
  localparam longint          PosMax        = 64'sd2147483647;
  localparam longint          PosMin        = -64'sd2147483648;
  localparam int              ShortRun      = 40;
  localparam int              RandomItems   = 400;
  localparam int              LongHold      = 300;
  localparam int              SettleCycles  = 50;
  localparam longint unsigned CycleLimit    = 64'd20_000_000;
  localparam logic            FuncTick      = 1'b0;
  localparam logic            FuncMove      = 1'b1;

  typedef enum int {IdleNone, IdleRare, IdleFull} idle_mode_e;

  class stepper_scoreboard;
    logic [9:0]         speed_rpm;
    logic signed [31:0] cur_pos;
    logic signed [31:0] tgt_pos;
    logic [19:0]        elapsed_acc;
    logic [17:0]        interval_ns;
    logic               moving;
    logic               dir;
    stm_pkg::out_t      expected_reports[$];
    int unsigned        errors;
    int unsigned        checked;
    int unsigned        microsteps;
    int unsigned        arrivals;
    int unsigned        moves_taken;
    int unsigned        status_count[4];

    function new();
      speed_rpm   = stm_pkg::RpmReset;
      cur_pos     = '0;
      tgt_pos     = '0;
      elapsed_acc = '0;
      interval_ns = '0;
      moving      = 1'b0;
      dir         = 1'b0;
    endfunction

    function void set_speed(logic [9:0] value);
      speed_rpm = value;
    endfunction

    function bit in_motion();
      return moving;
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

    // Works out the report for one accepted transfer and advances the state.
    function void apply_item(stm_pkg::in_t item);
      stm_pkg::out_t     rep;
      int                req_mm;
      longint            aim;
      logic [9:0]        rpm;
      longint unsigned   quo;
      int unsigned       sum;
      rep    = '0;
      req_mm = $signed(item.move_mm);
      if (item.func == FuncMove) begin
        if (req_mm < -stm_pkg::DistLimit || req_mm > stm_pkg::DistLimit) begin
          rep.status = stm_pkg::StatusRange;
        end else if (req_mm == 0) begin
          rep.status = stm_pkg::StatusZero;
        end else if (moving) begin
          rep.status = stm_pkg::StatusBusy;
        end else begin
          aim = longint'(cur_pos) + longint'(req_mm) * stm_pkg::UstepsPerMm;
          if (aim > PosMax) aim = PosMax;
          if (aim < PosMin) aim = PosMin;
          tgt_pos = aim[31:0];
          rpm = speed_rpm;
          if (rpm < stm_pkg::RpmMin) rpm = stm_pkg::RpmMin;
          if (rpm > stm_pkg::RpmMax) rpm = stm_pkg::RpmMax;
          quo = 64'(stm_pkg::NsPerMinute) / (64'(rpm) * 64'(UstepsPerRev));
          if (quo > 64'(stm_pkg::IntervalMax)) quo = 64'(stm_pkg::IntervalMax);
          interval_ns = quo[17:0];
          elapsed_acc = '0;
          moving      = (tgt_pos != cur_pos);
          moves_taken++;
        end
        status_count[rep.status]++;
      end else if (moving) begin
        sum = elapsed_acc + TickNs;
        if (sum > stm_pkg::ElapsedMax) sum = stm_pkg::ElapsedMax;
        elapsed_acc = sum[19:0];
        if (elapsed_acc >= interval_ns) begin
          if (tgt_pos > cur_pos) begin
            dir     = 1'b0;
            cur_pos = cur_pos + 1;
          end else begin
            dir     = 1'b1;
            cur_pos = cur_pos - 1;
          end
          rep.step_pulse = 1'b1;
          elapsed_acc    = '0;
          microsteps++;
          if (cur_pos == tgt_pos) begin
            moving       = 1'b0;
            rep.done_res = 1'b1;
            arrivals++;
          end
        end
      end
      rep.direction = dir;
      rep.position  = cur_pos;
      rep.moving    = moving;
      expected_reports.push_back(rep);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
        errors++;
      end
    endfunction

    function void check_report(stm_pkg::out_t got);
      stm_pkg::out_t want;
      if (expected_reports.size() == 0) begin
        $error("Report arrived with nothing expected: %p", got);
        errors++;
        return;
      end
      want = expected_reports.pop_front();
      checked++;
      compare_field("step_pulse", 32'(want.step_pulse), 32'(got.step_pulse));
      compare_field("direction", 32'(want.direction), 32'(got.direction));
      compare_field("position", want.position, got.position);
      compare_field("moving", 32'(want.moving), 32'(got.moving));
      compare_field("done_res", 32'(want.done_res), 32'(got.done_res));
      compare_field("status", 32'(want.status), 32'(got.status));
    endfunction
  endclass

  logic            clk       = 1'b0;
  logic            rst_n     = 1'b0;
  logic            in_valid  = 1'b0;
  stm_pkg::in_t    in_data   = '0;
  logic            out_stall = 1'b0;
  logic            cfg_we    = 1'b0;
  logic [9:0]      cfg_data  = '0;
  logic            in_stall;
  logic            out_valid;
  stm_pkg::out_t   out_data;

  stepper_scoreboard rpt;
  idle_mode_e        tx_mode   = IdleFull;
  idle_mode_e        rx_mode   = IdleFull;
  bit                hold_req  = 1'b0;
  int unsigned       hold_left = 0;
  int unsigned       rx_wait   = 0;
  longint unsigned   cycles    = 0;

  stepper_move_to_target dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  always @(posedge clk) cycles <= cycles + 1;

  function automatic int unsigned draw_gap(idle_mode_e mode);
    case (mode)
      IdleNone: return 0;
      IdleRare: return ($urandom_range(0, 31) == 0) ? $urandom_range(0, 14) : 0;
      default:  return $urandom_range(0, 14);
    endcase
  endfunction

  function automatic stm_pkg::in_t make_item(logic func, int req_mm);
    stm_pkg::in_t item;
    item.func    = func;
    item.move_mm = 8'(req_mm);
    return item;
  endfunction

  function automatic stm_pkg::in_t random_item(int unsigned move_pct);
    stm_pkg::in_t item;
    item.func    = ($urandom_range(0, 99) < move_pct) ? FuncMove : FuncTick;
    item.move_mm = 8'($urandom_range(0, 255));
    return item;
  endfunction

  // Output side: each report transfer is checked, then the next stall is drawn.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = LongHold;
    end
    if (rst_n && out_valid && !out_stall) begin
      rpt.check_report(out_data);
      rx_wait = draw_gap(rx_mode);
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(input stm_pkg::in_t item);
    int unsigned gap;
    gap = draw_gap(tx_mode);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    rpt.apply_item(item);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (rpt.pending() != 0);
  endtask

  task automatic write_speed(input logic [9:0] value);
    cfg_data <= value;
    cfg_we   <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    rpt.set_speed(value);
    @(negedge clk);
  endtask

  initial begin : watchdog
    wait (cycles >= CycleLimit);
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [9:0] speed;
    rpt = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Ticks and commands rejected from the idle state, in check priority order.
    send_item(make_item(FuncTick, 0));
    send_item(make_item(FuncTick, -128));
    send_item(make_item(FuncMove, -128));
    send_item(make_item(FuncMove, 127));
    send_item(make_item(FuncMove, -101));
    send_item(make_item(FuncMove, 101));
    send_item(make_item(FuncMove, 0));
    send_item(make_item(FuncTick, 127));
    drain();

    // Out-of-range speeds clamp; the move starts at the fastest setting.
    write_speed(10'd0);
    write_speed(stm_pkg::RpmMin);
    write_speed(10'd1023);
    send_item(make_item(FuncMove, -1));
    send_item(make_item(FuncMove, 1));
    send_item(make_item(FuncMove, 100));
    send_item(make_item(FuncMove, -100));
    send_item(make_item(FuncMove, 0));
    send_item(make_item(FuncMove, -101));

    tx_mode = IdleRare;
    rx_mode = IdleRare;
    repeat (ShortRun) send_item(random_item(5));
    send_item(make_item(FuncTick, 0));
    drain();

    case ($urandom_range(0, 3))
      0:       speed = stm_pkg::RpmMax;
      1:       speed = 10'd1023;
      2:       speed = 10'($urandom_range(stm_pkg::RpmMin, stm_pkg::RpmMax));
      default: speed = $urandom_range(0, 1) ? stm_pkg::RpmMin :
                       10'($urandom_range(0, stm_pkg::RpmMin - 1));
    endcase
    write_speed(10'($urandom_range(0, 1023)));
    write_speed(speed);
    send_item(make_item(FuncMove, 100));

    for (int n = 0; n < RandomItems; n++) begin
      if (n % 40 == 0) begin
        tx_mode = idle_mode_e'($urandom_range(0, 2));
        rx_mode = idle_mode_e'($urandom_range(0, 2));
      end
      // The receiver holds off while the sender keeps pushing transfers.
      if (n == 150) begin
        hold_req = 1'b1;
        tx_mode  = IdleNone;
      end
      // A speed write mid-move must not disturb the latched interval.
      if (n == 300) begin
        drain();
        write_speed(10'($urandom_range(0, 1023)));
      end
      send_item(random_item(20));
    end

    drain();
    repeat (SettleCycles) @(negedge clk);

    $display("Checked %0d reports: %0d microsteps, %0d arrivals, %0d moves accepted.",
             rpt.checked, rpt.microsteps, rpt.arrivals, rpt.moves_taken);
    $display("Rejected range/zero/busy: %0d/%0d/%0d; move speed setting %0d rpm.",
             rpt.status_count[stm_pkg::StatusRange], rpt.status_count[stm_pkg::StatusZero],
             rpt.status_count[stm_pkg::StatusBusy], speed);
    if (rpt.errors == 0 && rpt.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
